### rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HEAD = 2'd0,
        OP_PUSH_TAIL = 2'd1,
        OP_POP_HEAD  = 2'd2,
        OP_POP_TAIL  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NULL  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef logic [ITEM_WIDTH-1:0] item_t;

    // per-cell control, one per clock
    typedef struct packed {
        logic shift_tail;  // take the neighbour on the head side
        logic shift_head;  // take the neighbour on the tail side
        logic load;        // take the pushed item directly
    } cell_ctl_t;

endpackage

### rtl/double_ended_queue.sv
// channel | dir | tdata (low bit up)            | tuser      | tlast
// s_      | in  | item[31:0], zero pad to 40     | op[1:0]    | -
// m_      | out | item_out[31:0], count[36:32],  | status[1:0]| -
//         |     | zero pad to 40                 |            |
//
// one operation per cycle; the result is registered and valid in the cycle after the transaction
// the entries sit in a row of cells, cell 0 always the head; a head push or pop
// shifts the whole row by one place, a tail push loads the cell at the count
// reset (rst_n, asynchronous) empties the queue; cell contents are not cleared
// the result register frees when taken, so input stalls only while m_tvalid is
// high and m_tready low
module double_ended_queue import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item[31:0], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // item_out[31:0], count[36:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    // entries held, plus the registered result
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    status_t            out_status_next;
    item_t              out_item_reg;
    item_t              out_item_next;
    logic [COUNT_W-1:0] out_count_reg;

    logic      in_fire;
    op_t       op;
    item_t     item;
    status_t   status;
    logic      success;
    item_t     tail_data;
    item_t     cell_data [DEPTH];
    cell_ctl_t cell_ctl  [DEPTH];

    assign op       = op_t'(s_tuser);
    assign item     = s_tdata[ITEM_WIDTH-1:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // status of the operation on offer, from the current fill
    always_comb
    begin
        unique case (op)
            OP_PUSH_HEAD, OP_PUSH_TAIL:
            begin
                if (item == '0)
                begin
                    status = ST_NULL;
                end
                else if (count_reg >= COUNT_W'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status = ST_OK;
                end
            end
            OP_POP_HEAD, OP_POP_TAIL:
            begin
                status = (count_reg == '0) ? ST_EMPTY : ST_OK;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    assign success = in_fire && (status == ST_OK);

    // the tail entry lives in the cell just below the count
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (count_reg == COUNT_W'(i + 1))
            begin
                tail_data = tail_data | cell_data[i];
            end
        end
    end

    // per-cell moves
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctl[i].shift_tail = success && (op == OP_PUSH_HEAD);
            cell_ctl[i].shift_head = success && (op == OP_POP_HEAD);
            cell_ctl[i].load       = success && (op == OP_PUSH_TAIL)
                                     && (count_reg == COUNT_W'(i));
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            item_t head_side;
            item_t tail_side;

            if (g == 0)
            begin : g_first
                assign head_side = item;
            end
            else
            begin : g_inner_h
                assign head_side = cell_data[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign tail_side = cell_data[g];
            end
            else
            begin : g_inner_t
                assign tail_side = cell_data[g+1];
            end

            deq_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[g]),
                .item      (item),
                .head_side (head_side),
                .tail_side (tail_side),
                .data      (cell_data[g])
            );
        end
    endgenerate

    // count and result next values
    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        if (in_fire)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status;
            out_item_next   = '0;
            if (status == ST_OK)
            begin
                case (op)
                    OP_PUSH_HEAD, OP_PUSH_TAIL:
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    OP_POP_HEAD:
                    begin
                        count_next    = count_reg - COUNT_W'(1);
                        out_item_next = cell_data[0];
                    end
                    default:
                    begin
                        count_next    = count_reg - COUNT_W'(1);
                        out_item_next = tail_data;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_item_reg   <= out_item_next;
        if (in_fire)
        begin
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(40 - ITEM_WIDTH - COUNT_W){1'b0}}, out_count_reg, out_item_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> m_tvalid)
        else $error("transaction gave no result");

    a_fail_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg != ST_OK) |-> (out_item_reg == '0))
        else $error("failed operation returned an item");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (success && (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL))
        |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("push did not grow the count");
`endif

endmodule

### rtl/deq_cell.sv
module deq_cell import deq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  item_t     item,
    input  item_t     head_side,
    input  item_t     tail_side,
    output item_t     data
);

    item_t data_reg;
    item_t data_next;

    always_comb
    begin
        if (ctl.load)
        begin
            data_next = item;
        end
        else if (ctl.shift_tail)
        begin
            data_next = head_side;
        end
        else if (ctl.shift_head)
        begin
            data_next = tail_side;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
